FILE: src/tcc_pkg.sv
// shared types, constants and a helper function for the tick calendar clock
package tcc_pkg;

   localparam int TICK_MS = 10;

   localparam int YEAR_W     = 14;
   localparam int MONTH_W    = 4;
   localparam int DAY_W      = 5;
   localparam int HOUR_W     = 5;
   localparam int MINUTE_W   = 6;
   localparam int SECOND_W   = 6;
   localparam int MILLI_W    = 10;
   localparam int UPTIME_W   = 32;
   localparam int INTERVAL_W = 18;
   localparam int CFG_W      = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_QUANTUM  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCHED_PERIOD = 1'd1;

   localparam logic [CFG_W-1:0] MIN_QUANTUM_RST  = 16'd0;
   localparam logic [CFG_W-1:0] SCHED_PERIOD_RST = 16'd10;

   localparam logic [MILLI_W:0]    MS_PER_SEC  = 11'd1000;
   localparam logic [MILLI_W-1:0]  MILLI_MAX   = 10'd999;
   localparam logic [MILLI_W:0]    TICK_MILLI  = 11'(TICK_MS);
   localparam logic [UPTIME_W-1:0] TICK_UPTIME = 32'(TICK_MS);
   localparam logic [INTERVAL_W-1:0] TICK_INTERVAL = 18'(TICK_MS);
   localparam logic [SECOND_W-1:0] SEC_PER_MIN = 6'd60;
   localparam logic [MINUTE_W-1:0] MIN_PER_HOUR = 6'd60;
   localparam logic [HOUR_W-1:0]   HOUR_PER_DAY = 5'd24;
   localparam logic [MONTH_W-1:0]  MONTH_LAST  = 4'd12;

   // reciprocal of 25 for the century test, exact for 14-bit years
   localparam int RECIP25_SHIFT = 17;
   localparam logic [12:0] RECIP25 = 13'd5243;

   localparam logic [YEAR_W-1:0]  YEAR_RST  = 14'd2000;
   localparam logic [MONTH_W-1:0] MONTH_RST = 4'd1;
   localparam logic [DAY_W-1:0]   DAY_RST   = 5'd1;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic [MILLI_W-1:0]  milli;
   } cal_type;

   localparam cal_type CAL_RST = '{
      year: YEAR_RST, month: MONTH_RST, day: DAY_RST,
      hour: '0, minute: '0, second: '0, milli: '0
   };

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (month)
         4'd1:    len = 5'd31;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: src/tcc_calendar.sv
// next calendar value for one tick or set item
module tcc_calendar import tcc_pkg::*; (
   input  logic    op,
   input  cal_type cur,
   input  cal_type load,
   output cal_type nxt
);

   logic [YEAR_W+12:0]  recip_prod;
   logic [MILLI_W-1:0]  century_q;
   logic [YEAR_W:0]     century_back;
   logic                div25;
   logic                leap;
   logic [MILLI_W:0]    milli_sum;
   logic [SECOND_W-1:0] sec_inc;
   logic [MINUTE_W-1:0] min_inc;
   logic [HOUR_W-1:0]   hour_inc;
   logic [DAY_W-1:0]    day_inc;
   logic [MONTH_W-1:0]  month_inc;
   logic [DAY_W-1:0]    len;

   assign recip_prod   = {13'd0, cur.year} * {14'd0, RECIP25};
   assign century_q    = recip_prod[RECIP25_SHIFT +: MILLI_W];
   assign century_back = 15'({5'd0, century_q} * 15'd25);
   assign div25        = (century_back == {1'b0, cur.year});
   assign leap         = (cur.year[1:0] == 2'd0) && (!div25 || (cur.year[3:0] == 4'd0));
   assign len          = month_len(cur.month, leap);

   assign milli_sum = {1'b0, cur.milli} + TICK_MILLI;
   assign sec_inc   = cur.second + 6'd1;
   assign min_inc   = cur.minute + 6'd1;
   assign hour_inc  = cur.hour + 5'd1;
   assign day_inc   = cur.day + 5'd1;
   assign month_inc = cur.month + 4'd1;

   always_comb begin
      nxt = cur;
      if (op == OP_SET) begin
         nxt = load;
         if (load.milli > MILLI_MAX) begin
            nxt.milli = MILLI_MAX;
         end
      end else begin
         nxt.milli = milli_sum[MILLI_W-1:0];
         if (milli_sum >= MS_PER_SEC) begin
            nxt.milli  = 10'(milli_sum - MS_PER_SEC);
            nxt.second = sec_inc;
            if (sec_inc >= SEC_PER_MIN) begin
               nxt.second = '0;
               nxt.minute = min_inc;
               if (min_inc >= MIN_PER_HOUR) begin
                  nxt.minute = '0;
                  nxt.hour   = hour_inc;
                  if (hour_inc >= HOUR_PER_DAY) begin
                     nxt.hour = '0;
                     nxt.day  = day_inc;
                     if (day_inc > len) begin
                        nxt.day   = DAY_RST;
                        nxt.month = month_inc;
                        if (month_inc > MONTH_LAST || month_inc == 4'd0) begin
                           nxt.month = MONTH_RST;
                           nxt.year  = cur.year + 14'd1;
                        end
                     end
                  end
               end
            end
         end
      end
   end

endmodule

FILE: src/tcc_timebase.sv
// uptime and scheduler interval counters
module tcc_timebase import tcc_pkg::*; (
   input  logic                  op,
   input  logic [UPTIME_W-1:0]   uptime,
   input  logic [INTERVAL_W-1:0] interval,
   input  logic [CFG_W-1:0]      min_quantum,
   input  logic [CFG_W-1:0]      sched_period,
   output logic [UPTIME_W-1:0]   uptime_nxt,
   output logic [INTERVAL_W-1:0] interval_nxt,
   output logic                  pulse
);

   logic [CFG_W:0]        threshold;
   logic [INTERVAL_W-1:0] interval_sum;

   assign threshold    = {1'b0, min_quantum} + {1'b0, sched_period};
   assign interval_sum = interval + TICK_INTERVAL;

   always_comb begin
      uptime_nxt   = uptime;
      interval_nxt = interval;
      pulse        = 1'b0;
      if (op == OP_TICK) begin
         uptime_nxt   = uptime + TICK_UPTIME;
         interval_nxt = interval_sum;
         if (interval_sum >= 18'(threshold)) begin
            interval_nxt = '0;
            pulse        = 1'b1;
         end
      end
   end

endmodule

FILE: src/tick_calendar_clock_core.sv
// top level of the tick calendar clock: input stage, state, result stage
// Each item (a tick or a calendar set) is taken into the input register and
// moves on into the result register once that is empty or being taken, so
// the result sits on the result ports until the receiver takes it. A new
// item is taken every cycle while the result side does not stall; the
// calendar carry chain and the leap-year test (one small multiply by the
// reciprocal of 25) sit in the single stage between the input register and
// the calendar/result registers, which sets the clock period. Configuration
// writes are always ready and take effect on the next tick.
module tick_calendar_clock_core import tcc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   input  logic [YEAR_W-1:0]     req_new_year,
   input  logic [MONTH_W-1:0]    req_new_month,
   input  logic [DAY_W-1:0]      req_new_day,
   input  logic [HOUR_W-1:0]     req_new_hour,
   input  logic [MINUTE_W-1:0]   req_new_minute,
   input  logic [SECOND_W-1:0]   req_new_second,
   input  logic [MILLI_W-1:0]    req_new_milli,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [YEAR_W-1:0]     rsp_year,
   output logic [MONTH_W-1:0]    rsp_month,
   output logic [DAY_W-1:0]      rsp_day,
   output logic [HOUR_W-1:0]     rsp_hour,
   output logic [MINUTE_W-1:0]   rsp_minute,
   output logic [SECOND_W-1:0]   rsp_second,
   output logic [MILLI_W-1:0]    rsp_milli,
   output logic [UPTIME_W-1:0]   rsp_uptime_ms,
   output logic                  rsp_schedule_now,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   logic                  in_valid_ff;
   logic                  in_op_ff;
   cal_type               in_cal_ff;
   cal_type               cal_ff, cal_in;
   logic [UPTIME_W-1:0]   uptime_ff, uptime_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [CFG_W-1:0]      min_quantum_ff, sched_period_ff;
   logic                  out_valid_ff;
   cal_type               out_cal_ff;
   logic [UPTIME_W-1:0]   out_uptime_ff;
   logic                  out_sched_ff;
   logic                  pulse;
   logic                  advance;
   cal_type               req_cal;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign req_cal = '{
      year: req_new_year, month: req_new_month, day: req_new_day,
      hour: req_new_hour, minute: req_new_minute, second: req_new_second,
      milli: req_new_milli
   };

   tcc_calendar u_calendar (
      .op   (in_op_ff),
      .cur  (cal_ff),
      .load (in_cal_ff),
      .nxt  (cal_in)
   );

   tcc_timebase u_timebase (
      .op           (in_op_ff),
      .uptime       (uptime_ff),
      .interval     (interval_ff),
      .min_quantum  (min_quantum_ff),
      .sched_period (sched_period_ff),
      .uptime_nxt   (uptime_in),
      .interval_nxt (interval_in),
      .pulse        (pulse)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff  <= req_operation;
         in_cal_ff <= req_cal;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_quantum_ff  <= MIN_QUANTUM_RST;
         sched_period_ff <= SCHED_PERIOD_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_QUANTUM:  min_quantum_ff  <= csr_wdata;
            CSR_SCHED_PERIOD: sched_period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff      <= CAL_RST;
         uptime_ff   <= '0;
         interval_ff <= '0;
      end else if (advance) begin
         cal_ff      <= cal_in;
         uptime_ff   <= uptime_in;
         interval_ff <= interval_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_cal_ff    <= cal_in;
         out_uptime_ff <= uptime_in;
         out_sched_ff  <= pulse;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_year         = out_cal_ff.year;
   assign rsp_month        = out_cal_ff.month;
   assign rsp_day          = out_cal_ff.day;
   assign rsp_hour         = out_cal_ff.hour;
   assign rsp_minute       = out_cal_ff.minute;
   assign rsp_second       = out_cal_ff.second;
   assign rsp_milli        = out_cal_ff.milli;
   assign rsp_uptime_ms    = out_uptime_ff;
   assign rsp_schedule_now = out_sched_ff;

endmodule

FILE: src/tcc_checker.sv
// port-level checks for the tick calendar clock and their bind
module tcc_checker import tcc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [MILLI_W-1:0]  rsp_milli,
   input logic [UPTIME_W-1:0] rsp_uptime_ms
);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_uptime_ms) && $stable(rsp_milli))
      else $error("result item changed while stalled");

   // millisecond never reaches a full second
   a_milli_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_milli <= MILLI_MAX)
      else $error("millisecond out of range");

   // no result item straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item valid after reset");

endmodule

bind tick_calendar_clock_core tcc_checker u_tcc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_milli     (rsp_milli),
   .rsp_uptime_ms (rsp_uptime_ms)
);

FILE: verif/tb.sv
// self-checking testbench for tick_calendar_clock_core: calendar predictor with random traffic
module tb;
   import tcc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT   = 2000;
   localparam int LONG_HOLD     = 80;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 250;
   localparam int MAX_SHOWN     = 40;

   typedef struct packed {
      logic    op;
      cal_type cal;
   } clock_req_type;

   typedef struct packed {
      cal_type             cal;
      logic [UPTIME_W-1:0] uptime;
      logic                pulse;
   } clock_reading_type;

   typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_EVERY_THIRD} rx_mode_type;

   localparam int REQ_W = $bits(clock_req_type);

   class calendar_scoreboard;
      logic [CFG_W-1:0]       min_quantum;
      logic [CFG_W-1:0]       sched_period;
      cal_type                cal;
      logic [UPTIME_W-1:0]    uptime;
      logic [INTERVAL_W-1:0]  interval;
      clock_reading_type      expected_readings[$];
      int                     errors;
      int unsigned            month_table[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

      function new();
         min_quantum  = MIN_QUANTUM_RST;
         sched_period = SCHED_PERIOD_RST;
         cal          = CAL_RST;
         uptime       = '0;
         interval     = '0;
         errors       = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
         case (idx)
            CSR_MIN_QUANTUM:  min_quantum = value;
            CSR_SCHED_PERIOD: sched_period = value;
            default: ;
         endcase
      endfunction

      function bit leap(logic [YEAR_W-1:0] y);
         int unsigned v;
         v = 32'(y);
         return (v % 400 == 0) || ((v % 4 == 0) && (v % 100 != 0));
      endfunction

      function int unsigned days_in(logic [MONTH_W-1:0] m, logic [YEAR_W-1:0] y);
         int unsigned len;
         if (m < 1 || m > MONTH_LAST) return 31;
         len = month_table[m - 1];
         if (m == 2 && leap(y)) len++;
         return len;
      endfunction

      // carry of one whole second through the calendar
      function void roll_second();
         cal.second = cal.second + 1'b1;
         if (cal.second < SEC_PER_MIN) return;
         cal.second = '0;
         cal.minute = cal.minute + 1'b1;
         if (cal.minute < MIN_PER_HOUR) return;
         cal.minute = '0;
         cal.hour = cal.hour + 1'b1;
         if (cal.hour < HOUR_PER_DAY) return;
         cal.hour = '0;
         cal.day = cal.day + 1'b1;
         if (cal.day <= days_in(cal.month, cal.year)) return;
         cal.day = DAY_RST;
         cal.month = cal.month + 1'b1;
         if (cal.month > MONTH_LAST || cal.month == 0) begin
            cal.month = MONTH_RST;
            cal.year = cal.year + 1'b1;
         end
      endfunction

      function void note_item(clock_req_type it);
         clock_reading_type r;
         int unsigned       milli_sum;
         r.pulse = 1'b0;
         if (it.op == OP_SET) begin
            cal = it.cal;
            if (it.cal.milli > MILLI_MAX) cal.milli = MILLI_MAX;
         end else begin
            uptime = uptime + TICK_UPTIME;
            interval = interval + TICK_INTERVAL;
            milli_sum = cal.milli + TICK_MS;
            while (milli_sum >= MS_PER_SEC) begin
               milli_sum -= MS_PER_SEC;
               roll_second();
            end
            cal.milli = MILLI_W'(milli_sum);
            if (interval >= min_quantum + sched_period) begin
               interval = '0;
               r.pulse = 1'b1;
            end
         end
         r.cal = cal;
         r.uptime = uptime;
         expected_readings.push_back(r);
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         if (errors < MAX_SHOWN)
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
         errors++;
      endtask

      task check_result(clock_reading_type got);
         clock_reading_type want;
         if (expected_readings.size() == 0) begin
            report_mismatch("result with no item pending, uptime", got.uptime, 0);
            return;
         end
         want = expected_readings.pop_front();
         if (got.cal.year !== want.cal.year)
            report_mismatch("year", 32'(got.cal.year), 32'(want.cal.year));
         if (got.cal.month !== want.cal.month)
            report_mismatch("month", 32'(got.cal.month), 32'(want.cal.month));
         if (got.cal.day !== want.cal.day)
            report_mismatch("day", 32'(got.cal.day), 32'(want.cal.day));
         if (got.cal.hour !== want.cal.hour)
            report_mismatch("hour", 32'(got.cal.hour), 32'(want.cal.hour));
         if (got.cal.minute !== want.cal.minute)
            report_mismatch("minute", 32'(got.cal.minute), 32'(want.cal.minute));
         if (got.cal.second !== want.cal.second)
            report_mismatch("second", 32'(got.cal.second), 32'(want.cal.second));
         if (got.cal.milli !== want.cal.milli)
            report_mismatch("milli", 32'(got.cal.milli), 32'(want.cal.milli));
         if (got.uptime !== want.uptime)
            report_mismatch("uptime_ms", got.uptime, want.uptime);
         if (got.pulse !== want.pulse)
            report_mismatch("schedule_now", 32'(got.pulse), 32'(want.pulse));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_operation;
   logic [YEAR_W-1:0]    req_new_year;
   logic [MONTH_W-1:0]   req_new_month;
   logic [DAY_W-1:0]     req_new_day;
   logic [HOUR_W-1:0]    req_new_hour;
   logic [MINUTE_W-1:0]  req_new_minute;
   logic [SECOND_W-1:0]  req_new_second;
   logic [MILLI_W-1:0]   req_new_milli;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [YEAR_W-1:0]    rsp_year;
   logic [MONTH_W-1:0]   rsp_month;
   logic [DAY_W-1:0]     rsp_day;
   logic [HOUR_W-1:0]    rsp_hour;
   logic [MINUTE_W-1:0]  rsp_minute;
   logic [SECOND_W-1:0]  rsp_second;
   logic [MILLI_W-1:0]   rsp_milli;
   logic [UPTIME_W-1:0]  rsp_uptime_ms;
   logic                 rsp_schedule_now;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   calendar_scoreboard cal_sb = new();
   int                 burst_left = 0;
   int                 idle_cycles = 0;
   bit                 hold_request = 1'b0;

   tick_calendar_clock_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_new_year     (req_new_year),
      .req_new_month    (req_new_month),
      .req_new_day      (req_new_day),
      .req_new_hour     (req_new_hour),
      .req_new_minute   (req_new_minute),
      .req_new_second   (req_new_second),
      .req_new_milli    (req_new_milli),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day          (rsp_day),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .rsp_milli        (rsp_milli),
      .rsp_uptime_ms    (rsp_uptime_ms),
      .rsp_schedule_now (rsp_schedule_now),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      clock_reading_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.cal.year   = rsp_year;
         seen.cal.month  = rsp_month;
         seen.cal.day    = rsp_day;
         seen.cal.hour   = rsp_hour;
         seen.cal.minute = rsp_minute;
         seen.cal.second = rsp_second;
         seen.cal.milli  = rsp_milli;
         seen.uptime     = rsp_uptime_ms;
         seen.pulse      = rsp_schedule_now;
         cal_sb.check_result(seen);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin
      rx_mode_type rx_mode;
      int          pattern_left;
      int unsigned rx_cycle;
      rsp_ready = 1'b0;
      rx_mode = RX_OPEN;
      pattern_left = 0;
      rx_cycle = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (pattern_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(16, 96);
         end
         pattern_left--;
         rx_cycle++;
         case (rx_mode)
            RX_OPEN:        rsp_ready <= 1'b1;
            RX_MOSTLY:      rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE:      rsp_ready <= ($urandom_range(0, 3) == 0);
            RX_EVERY_THIRD: rsp_ready <= (rx_cycle % 3 == 0);
            default:        rsp_ready <= 1'b1;
         endcase
      end
   end

   task automatic send_item(clock_req_type it);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 24);
      end
      req_valid      <= 1'b1;
      req_operation  <= it.op;
      req_new_year   <= it.cal.year;
      req_new_month  <= it.cal.month;
      req_new_day    <= it.cal.day;
      req_new_hour   <= it.cal.hour;
      req_new_minute <= it.cal.minute;
      req_new_second <= it.cal.second;
      req_new_milli  <= it.cal.milli;
      do @(posedge clock); while (!(req_valid && req_ready));
      burst_left--;
      cal_sb.note_item(it);
   endtask

   task automatic send_set(int y, int mo, int d, int h, int mi, int s, int ms);
      clock_req_type it;
      it.op = OP_SET;
      it.cal.year   = YEAR_W'(y);
      it.cal.month  = MONTH_W'(mo);
      it.cal.day    = DAY_W'(d);
      it.cal.hour   = HOUR_W'(h);
      it.cal.minute = MINUTE_W'(mi);
      it.cal.second = SECOND_W'(s);
      it.cal.milli  = MILLI_W'(ms);
      send_item(it);
   endtask

   // tick payload is don't-care, so it carries random bits
   task automatic send_ticks(int count);
      clock_req_type it;
      for (int i = 0; i < count; i++) begin
         it = REQ_W'({$urandom, $urandom});
         it.op = OP_TICK;
         send_item(it);
      end
   endtask

   function automatic clock_req_type random_set_item();
      clock_req_type it;
      int unsigned   len;
      it = REQ_W'({$urandom, $urandom});
      it.op = OP_SET;
      if ($urandom_range(0, 6) == 0) return it;
      case ($urandom_range(0, 3))
         0:       it.cal.year = YEAR_W'($urandom_range(0, 9999));
         1:       it.cal.year = YEAR_W'(100 * $urandom_range(0, 99));
         2:       it.cal.year = YEAR_W'(4 * $urandom_range(0, 2499));
         default: it.cal.year = YEAR_W'($urandom_range(1990, 2110));
      endcase
      it.cal.month = MONTH_W'($urandom_range(1, 12));
      len = cal_sb.days_in(it.cal.month, it.cal.year);
      if ($urandom_range(0, 1) == 0) begin
         // just short of midnight at month end
         it.cal.day    = DAY_W'($urandom_range(len - 1, len));
         it.cal.hour   = HOUR_PER_DAY - 1'b1;
         it.cal.minute = MIN_PER_HOUR - 1'b1;
         it.cal.second = SEC_PER_MIN - 1'b1;
         it.cal.milli  = MILLI_W'($urandom_range(990, 999));
      end else begin
         it.cal.day    = DAY_W'($urandom_range(1, len));
         it.cal.hour   = HOUR_W'($urandom_range(0, 23));
         it.cal.minute = MINUTE_W'($urandom_range(0, 59));
         it.cal.second = SECOND_W'($urandom_range(0, 59));
         it.cal.milli  = MILLI_W'($urandom_range(0, 1023));
      end
      return it;
   endfunction

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (cal_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      cal_sb.write_reg(idx, value);
   endtask

   task automatic configure(logic [CFG_W-1:0] quantum, logic [CFG_W-1:0] period);
      drain_results();
      write_csr(CSR_MIN_QUANTUM, quantum);
      write_csr(CSR_SCHED_PERIOD, period);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int sent;
      int run;
      bit hold_done;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = OP_TICK;
      req_new_year   = '0;
      req_new_month  = '0;
      req_new_day    = '0;
      req_new_hour   = '0;
      req_new_minute = '0;
      req_new_second = '0;
      req_new_milli  = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_MIN_QUANTUM;
      csr_wdata      = '0;
      hold_done      = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_ticks(1);
      // leap by 400, not leap by 100, leap by 4
      send_set(2000, 2, 28, 23, 59, 59, 990);
      send_ticks(1);
      send_set(1900, 2, 28, 23, 59, 59, 995);
      send_ticks(1);
      send_set(2004, 2, 29, 23, 59, 59, 999);
      send_ticks(1);
      // day past the month length
      send_set(2100, 2, 30, 23, 59, 59, 999);
      send_ticks(1);
      send_set(2023, 4, 30, 23, 59, 59, 990);
      send_ticks(1);
      send_set(1999, 12, 31, 23, 59, 59, 995);
      send_ticks(1);
      // month and day zero, hour and minute over limit, milli clamp
      send_set(0, 0, 0, 24, 60, 59, 1000);
      send_ticks(1);
      send_set(16383, 15, 31, 31, 63, 63, 1023);
      send_ticks(1);
      send_set(9999, 13, 31, 23, 59, 59, 990);
      send_ticks(1);
      send_set(0, 0, 0, 0, 0, 0, 0);
      send_ticks(1);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       configure('0, '0);
            1:       configure('1, '1);
            2:       configure(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 40)));
            3:       configure(CFG_W'($urandom_range(0, 40)), '0);
            4:       configure(CFG_W'($urandom), CFG_W'($urandom));
            default: configure(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(0, 200)));
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (phase == 2 && sent >= 60 && !hold_done) begin
               hold_request = 1'b1;
               hold_done = 1'b1;
            end
            send_item(random_set_item());
            run = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 12) : $urandom_range(20, 150);
            send_ticks(run);
            sent += run + 1;
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (cal_sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
